FILE: rtl/nps_pkg.sv
// nps_pkg: shared types, codes and constants of the nearest polygon side block
// used by nps_ctrl, nps_datapath and nearest_polygon_side, not by nps_ram; depends on nothing
`timescale 1ns / 1ps

package nps_pkg;

  localparam int IDX_BITS       = 5;
  localparam int STEP_BITS      = IDX_BITS + 1;
  localparam int CFG_IDX_BITS   = 2;
  localparam int DEF_MAX_SIDES  = 16;
  localparam int DEF_COORD_BITS = 24;

  localparam logic [IDX_BITS-1:0] NUM_SIDES_RESET = 5'd4;
  localparam logic [IDX_BITS-1:0] NO_COVER_SIDE   = 5'd1;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam logic [CFG_IDX_BITS-1:0] CFG_NUM_SIDES = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_CENTER_X  = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_CENTER_Y  = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic start;
    logic load;
    logic rd_en;
    logic rd_first;
    logic wrap;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [IDX_BITS-1:0] n_sides;
  } ctrl_status_t;

endpackage

FILE: rtl/nps_ram.sv
// nps_ram: generic single write port, single read port ram with registered read
// depends on nothing
`timescale 1ns / 1ps

module nps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/nps_ctrl.sv
// nps_ctrl: controller state machine, sequences loads, the side scan and the result
// depends on nps_pkg
`timescale 1ns / 1ps

module nps_ctrl #(
  parameter int MAX_SIDES = nps_pkg::DEF_MAX_SIDES
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         cmd,
  output logic                         out_valid,
  input  logic                         out_ready,
  input  nps_pkg::ctrl_status_t        status,
  output nps_pkg::ctrl_cmd_t           ctrl,
  output logic [$clog2(MAX_SIDES)-1:0] rd_addr
);

  localparam int AW = $clog2(MAX_SIDES);

  nps_pkg::state_t                   state, state_next;
  logic [nps_pkg::STEP_BITS-1:0]     step, step_next;
  logic [nps_pkg::STEP_BITS-1:0]     n_ext;
  logic                              out_valid_next;
  logic                              accept;

  assign n_ext   = nps_pkg::STEP_BITS'(status.n_sides);
  assign accept  = in_valid & in_ready;
  assign rd_addr = step[AW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= nps_pkg::ST_IDLE;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      step      <= step_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    step_next  = step;
    in_ready   = 1'b0;
    ctrl       = '0;
    unique case (state)
      nps_pkg::ST_IDLE: begin
        in_ready  = 1'b1;
        step_next = '0;
        if (accept) begin
          if (cmd == nps_pkg::CMD_QUERY) begin
            ctrl.start = 1'b1;
            state_next = (status.n_sides == '0) ? nps_pkg::ST_FINISH : nps_pkg::ST_SCAN;
          end else begin
            ctrl.load = 1'b1;
          end
        end
      end
      nps_pkg::ST_SCAN: begin
        ctrl.rd_en    = (step < n_ext);
        ctrl.rd_first = (step == '0);
        ctrl.wrap     = (step == n_ext);
        if (step == n_ext + nps_pkg::STEP_BITS'(2)) begin
          state_next = nps_pkg::ST_FINISH;
        end else begin
          step_next = step + nps_pkg::STEP_BITS'(1);
        end
      end
      nps_pkg::ST_FINISH: begin
        if (!out_valid || out_ready) begin
          ctrl.out_load = 1'b1;
          state_next    = nps_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = nps_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid_next = ctrl.out_load | (out_valid & ~out_ready);

endmodule

FILE: rtl/nps_datapath.sv
// nps_datapath: configuration registers, side store, two stage side evaluation and
// best side tracking; depends on nps_pkg and nps_ram
`timescale 1ns / 1ps

module nps_datapath #(
  parameter int MAX_SIDES  = nps_pkg::DEF_MAX_SIDES,
  parameter int COORD_BITS = nps_pkg::DEF_COORD_BITS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  nps_pkg::ctrl_cmd_t                  ctrl,
  input  logic [$clog2(MAX_SIDES)-1:0]        rd_addr,
  output nps_pkg::ctrl_status_t               status,
  input  logic                                cfg_valid,
  input  logic [nps_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [COORD_BITS-1:0]               cfg_data,
  input  logic [nps_pkg::IDX_BITS-1:0]        side_index,
  input  logic                                side_is_vertical,
  input  logic signed [COORD_BITS-1:0]        side_position,
  input  logic signed [COORD_BITS-1:0]        vertex_x,
  input  logic signed [COORD_BITS-1:0]        vertex_y,
  input  logic signed [COORD_BITS-1:0]        query_x,
  input  logic signed [COORD_BITS-1:0]        query_y,
  output logic [nps_pkg::IDX_BITS-1:0]        nearest_side
);

  localparam int CW = COORD_BITS;
  localparam int EW = COORD_BITS + 1;
  localparam int AW = $clog2(MAX_SIDES);
  localparam int RW = 3 * COORD_BITS + 1;

  logic [nps_pkg::IDX_BITS-1:0] num_sides;
  logic signed [CW-1:0]         center_x, center_y;
  logic signed [CW-1:0]         qx, qy;

  // side store
  logic          we;
  logic [AW-1:0] waddr;
  logic [RW-1:0] wdata, rdata;

  assign we    = ctrl.load && (side_index != '0) && (int'(side_index) <= MAX_SIDES);
  assign waddr = AW'(side_index - nps_pkg::IDX_BITS'(1));
  assign wdata = {side_is_vertical, side_position, vertex_x, vertex_y};

  nps_ram #(
    .WIDTH(RW),
    .DEPTH(MAX_SIDES)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .re   (ctrl.rd_en),
    .raddr(rd_addr),
    .rdata(rdata)
  );

  logic                 r_flag;
  logic signed [CW-1:0] r_pos, r_vx, r_vy;

  assign r_flag = rdata[3*CW];
  assign r_pos  = $signed(rdata[3*CW-1:2*CW]);
  assign r_vx   = $signed(rdata[2*CW-1:CW]);
  assign r_vy   = $signed(rdata[CW-1:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      num_sides <= nps_pkg::NUM_SIDES_RESET;
      center_x  <= '0;
      center_y  <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        nps_pkg::CFG_NUM_SIDES: num_sides <= cfg_data[nps_pkg::IDX_BITS-1:0];
        nps_pkg::CFG_CENTER_X:  center_x  <= $signed(cfg_data);
        nps_pkg::CFG_CENTER_Y:  center_y  <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  assign status.n_sides = (int'(num_sides) > MAX_SIDES) ?
                          nps_pkg::IDX_BITS'(MAX_SIDES) : num_sides;

  // read side pipeline: held side waits for the next vertex
  logic                 rv, rfirst, rwrap;
  logic                 hold_flag;
  logic signed [CW-1:0] hold_pos, hold_vx, hold_vy;
  logic signed [CW-1:0] first_vx, first_vy;

  always_ff @(posedge clk) begin
    if (rst) begin
      rv     <= 1'b0;
      rfirst <= 1'b0;
      rwrap  <= 1'b0;
    end else begin
      rv     <= ctrl.rd_en;
      rfirst <= ctrl.rd_en & ctrl.rd_first;
      rwrap  <= ctrl.wrap;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      qx <= query_x;
      qy <= query_y;
    end
    if (rv) begin
      hold_flag <= r_flag;
      hold_pos  <= r_pos;
      hold_vx   <= r_vx;
      hold_vy   <= r_vy;
      if (rfirst) begin
        first_vx <= r_vx;
        first_vy <= r_vy;
      end
    end
  end

  // stage one: span ends and distance of the held side
  logic                 e_valid;
  logic signed [CW-1:0] nvx, nvy;
  logic signed [EW-1:0] b_end, e_end, along, diff;
  logic [EW-1:0]        side_dist;

  assign e_valid = (rv & ~rfirst) | rwrap;
  assign nvx     = rwrap ? first_vx : r_vx;
  assign nvy     = rwrap ? first_vy : r_vy;

  always_comb begin
    if (hold_flag) begin
      b_end = EW'(hold_vy) + EW'(center_y);
      e_end = EW'(nvy) + EW'(center_y);
      along = EW'(qy);
      diff  = EW'(qx) - EW'(hold_pos);
    end else begin
      b_end = EW'(hold_vx) + EW'(center_x);
      e_end = EW'(nvx) + EW'(center_x);
      along = EW'(qx);
      diff  = EW'(qy) - EW'(hold_pos);
    end
    side_dist = diff[EW-1] ? EW'(-diff) : EW'(diff);
  end

  logic                 s1_valid;
  logic signed [EW-1:0] s1_b, s1_e, s1_along;
  logic [EW-1:0]        s1_dist;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= e_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_b     <= b_end;
    s1_e     <= e_end;
    s1_along <= along;
    s1_dist  <= side_dist;
  end

  // stage two: coverage test and best side update, lowest index wins a tie
  logic                         covered, better;
  logic                         found;
  logic [nps_pkg::IDX_BITS-1:0] side_k, best;
  logic [EW-1:0]                best_dist;

  assign covered = ((s1_b <= s1_along) && (s1_along <= s1_e)) ||
                   ((s1_e <= s1_along) && (s1_along <= s1_b));
  assign better  = !found || (s1_dist < best_dist);

  always_ff @(posedge clk) begin
    if (rst) begin
      found <= 1'b0;
    end else if (ctrl.start) begin
      found <= 1'b0;
    end else if (s1_valid && covered && better) begin
      found <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      side_k <= nps_pkg::IDX_BITS'(1);
      best   <= nps_pkg::NO_COVER_SIDE;
    end else if (s1_valid) begin
      side_k <= side_k + nps_pkg::IDX_BITS'(1);
      if (covered && better) begin
        best      <= side_k;
        best_dist <= s1_dist;
      end
    end
    if (ctrl.out_load) begin
      nearest_side <= best;
    end
  end

endmodule

FILE: rtl/nearest_polygon_side.sv
// nearest_polygon_side: top level, joins the controller and the datapath
// depends on nps_pkg, nps_ctrl, nps_datapath and nps_ram
`timescale 1ns / 1ps

// Holds the sides of a rectilinear cell outline in a ram with one write and one read
// port and answers queries with the nearest side whose span covers the pin, lowest
// index on a tie, side 1 when none covers. A load item gives no result. A query item
// reads the stored sides one per cycle through the ram read port (their count clamped
// to MAX_SIDES), and its result is loaded into the output register once that register
// is free; the next item is taken the cycle after. Loads are accepted while a result
// waits at the output. Configuration writes are always taken and must only be made
// while no query is in flight.

module nearest_polygon_side #(
  parameter int MAX_SIDES  = nps_pkg::DEF_MAX_SIDES,
  parameter int COORD_BITS = nps_pkg::DEF_COORD_BITS
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [nps_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [COORD_BITS-1:0]            cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             cmd,
  input  logic [nps_pkg::IDX_BITS-1:0]     side_index,
  input  logic                             side_is_vertical,
  input  logic signed [COORD_BITS-1:0]     side_position,
  input  logic signed [COORD_BITS-1:0]     vertex_x,
  input  logic signed [COORD_BITS-1:0]     vertex_y,
  input  logic signed [COORD_BITS-1:0]     query_x,
  input  logic signed [COORD_BITS-1:0]     query_y,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [nps_pkg::IDX_BITS-1:0]     nearest_side
);

  nps_pkg::ctrl_cmd_t           ctrl;
  nps_pkg::ctrl_status_t        status;
  logic [$clog2(MAX_SIDES)-1:0] rd_addr;

  assign cfg_ready = 1'b1;

  nps_ctrl #(
    .MAX_SIDES(MAX_SIDES)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .status   (status),
    .ctrl     (ctrl),
    .rd_addr  (rd_addr)
  );

  nps_datapath #(
    .MAX_SIDES (MAX_SIDES),
    .COORD_BITS(COORD_BITS)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .ctrl            (ctrl),
    .rd_addr         (rd_addr),
    .status          (status),
    .cfg_valid       (cfg_valid),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .side_index      (side_index),
    .side_is_vertical(side_is_vertical),
    .side_position   (side_position),
    .vertex_x        (vertex_x),
    .vertex_y        (vertex_y),
    .query_x         (query_x),
    .query_y         (query_y),
    .nearest_side    (nearest_side)
  );

  a_result_in_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (nearest_side != '0) && (int'(nearest_side) <= MAX_SIDES))
    else $error("result side index out of range");

  a_query_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && (cmd == nps_pkg::CMD_QUERY)) |=> !in_ready)
    else $error("input taken while a query is in flight");

  a_result_not_overwritten: assert property (@(posedge clk) disable iff (rst)
    ctrl.out_load |-> (!out_valid || out_ready))
    else $error("result register loaded while a result still waits");

endmodule

FILE: tb/sv/nearest_polygon_side_test.sv
`timescale 1ns / 1ps
// nearest_polygon_side_test: self-checking bench for the nearest polygon side block,
// side loads, pin queries and register writes under random gaps and output stalls
// depends on nps_pkg and the rtl of nearest_polygon_side

module nearest_polygon_side_test;
  import nps_pkg::*;

  localparam int CB          = DEF_COORD_BITS;
  localparam int SIDES       = DEF_MAX_SIDES;
  localparam int SETTLE      = SIDES + 8;
  localparam int STALL_LIMIT = 4000;
  localparam int PHASES      = 12;
  localparam int PHASE_ITEMS = 90;
  localparam int REACH       = 64;
  localparam longint COORD_HI = (longint'(1) << (CB - 1)) - 1;
  localparam longint COORD_LO = -(longint'(1) << (CB - 1));
  localparam logic [CFG_IDX_BITS-1:0] CFG_UNUSED = 2'd3;

  typedef struct packed {
    logic                cmd;
    logic [IDX_BITS-1:0] side_index;
    logic                side_is_vertical;
    logic [CB-1:0]       side_position;
    logic [CB-1:0]       vertex_x;
    logic [CB-1:0]       vertex_y;
    logic [CB-1:0]       query_x;
    logic [CB-1:0]       query_y;
  } outline_op_t;

  typedef struct packed {
    outline_op_t         op;
    logic                typed;
    logic [IDX_BITS-1:0] answer;
  } directed_row_t;

  logic                     clk;
  logic                     rst = 1'b1;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
  logic [CB-1:0]            cfg_data = '0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic                     cmd = CMD_LOAD;
  logic [IDX_BITS-1:0]      side_index = '0;
  logic                     side_is_vertical = 1'b0;
  logic signed [CB-1:0]     side_position = '0;
  logic signed [CB-1:0]     vertex_x = '0;
  logic signed [CB-1:0]     vertex_y = '0;
  logic signed [CB-1:0]     query_x = '0;
  logic signed [CB-1:0]     query_y = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic [IDX_BITS-1:0]      nearest_side;

  // answer typed into the directed table travels with its item
  logic                     answer_typed = 1'b0;
  logic [IDX_BITS-1:0]      answer_given = NO_COVER_SIDE;

  logic                     side_vert [1:SIDES];
  logic signed [CB-1:0]     side_coord [1:SIDES];
  logic signed [CB-1:0]     corner_x [1:SIDES];
  logic signed [CB-1:0]     corner_y [1:SIDES];
  logic [IDX_BITS-1:0]      side_count_reg = NUM_SIDES_RESET;
  logic signed [CB-1:0]     center_x_reg = '0;
  logic signed [CB-1:0]     center_y_reg = '0;
  logic [IDX_BITS-1:0]      pending_nearest [$];
  directed_row_t            dir_rows [$];

  int mismatches   = 0;
  int results_seen = 0;
  int loads_seen   = 0;
  int queries_seen = 0;
  int reg_writes   = 0;
  int idle_cycles  = 0;
  int stall_mode   = 1;
  int ready_hold   = 0;

  nearest_polygon_side dut (
    .clk              (clk),
    .rst              (rst),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .cmd              (cmd),
    .side_index       (side_index),
    .side_is_vertical (side_is_vertical),
    .side_position    (side_position),
    .vertex_x         (vertex_x),
    .vertex_y         (vertex_y),
    .query_x          (query_x),
    .query_y          (query_y),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .nearest_side     (nearest_side)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic [IDX_BITS-1:0] nearest_covering_side(
    logic signed [CB-1:0] qx, logic signed [CB-1:0] qy);
    int                  n;
    int                  nx;
    longint              b, e, lo, hi, along, sep, best_sep;
    logic [IDX_BITS-1:0] best;
    bit                  found;
    n = (side_count_reg > SIDES) ? SIDES : int'(side_count_reg);
    best = NO_COVER_SIDE;
    best_sep = 0;
    found = 1'b0;
    for (int k = 1; k <= n; k++) begin
      nx = (k == n) ? 1 : k + 1;
      if (side_vert[k]) begin
        sep   = longint'(qx) - longint'(side_coord[k]);
        b     = longint'(corner_y[k]) + longint'(center_y_reg);
        e     = longint'(corner_y[nx]) + longint'(center_y_reg);
        along = longint'(qy);
      end else begin
        sep   = longint'(qy) - longint'(side_coord[k]);
        b     = longint'(corner_x[k]) + longint'(center_x_reg);
        e     = longint'(corner_x[nx]) + longint'(center_x_reg);
        along = longint'(qx);
      end
      if (sep < 0) begin
        sep = -sep;
      end
      lo = (b < e) ? b : e;
      hi = (b < e) ? e : b;
      if (lo <= along && along <= hi && (!found || sep < best_sep)) begin
        found = 1'b1;
        best_sep = sep;
        best = IDX_BITS'(k);
      end
    end
    return best;
  endfunction

  always @(posedge clk) begin : scoreboard
    logic [IDX_BITS-1:0] want;
    if (rst) begin
      side_count_reg = NUM_SIDES_RESET;
      center_x_reg = '0;
      center_y_reg = '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        reg_writes++;
        case (cfg_index)
          CFG_NUM_SIDES: side_count_reg = cfg_data[IDX_BITS-1:0];
          CFG_CENTER_X:  center_x_reg = cfg_data;
          CFG_CENTER_Y:  center_y_reg = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        if (cmd == CMD_QUERY) begin
          queries_seen++;
          pending_nearest.push_back(answer_typed ? answer_given
                                                 : nearest_covering_side(query_x, query_y));
        end else begin
          loads_seen++;
          if (side_index >= 1 && side_index <= SIDES) begin
            side_vert[side_index]  = side_is_vertical;
            side_coord[side_index] = side_position;
            corner_x[side_index]   = vertex_x;
            corner_y[side_index]   = vertex_y;
          end
        end
      end
      if (out_valid && out_ready) begin
        results_seen++;
        if (pending_nearest.size() == 0) begin
          if (mismatches < 10) begin
            $display("result %0d with nothing expected: nearest_side %0d",
                     results_seen, nearest_side);
          end
          mismatches++;
        end else begin
          want = pending_nearest.pop_front();
          if (nearest_side !== want) begin
            if (mismatches < 10) begin
              $display("result %0d: nearest_side expected %0d got %0d",
                       results_seen, want, nearest_side);
            end
            mismatches++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("no handshake for %0d cycles, %0d results outstanding",
               STALL_LIMIT, pending_nearest.size());
      $display("FAIL nearest_polygon_side");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  always @(negedge clk) begin : result_backpressure
    int r;
    if (ready_hold > 0) begin
      ready_hold = ready_hold - 1;
    end else if (stall_mode == 0) begin
      out_ready <= 1'b1;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 65) begin
        out_ready <= 1'b1;
        ready_hold = $urandom_range(0, 5);
      end else if (r < 94) begin
        out_ready <= 1'b0;
        ready_hold = $urandom_range(0, 2);
      end else begin
        out_ready <= 1'b0;
        ready_hold = $urandom_range(8, (stall_mode == 2) ? 60 : 16);
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (stall_mode == 0 || r < 55) begin
      return 0;
    end
    if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(6, (stall_mode == 2) ? 40 : 12);
  endfunction

  function automatic logic [CB-1:0] clamp_coord(longint v);
    if (v > COORD_HI) begin
      return CB'(COORD_HI);
    end
    if (v < COORD_LO) begin
      return CB'(COORD_LO);
    end
    return CB'(v);
  endfunction

  function automatic longint rel(int reach);
    return longint'($urandom_range(0, 2 * reach)) - reach;
  endfunction

  function automatic logic [CB-1:0] any_coord();
    case ($urandom_range(0, 7))
      0: return CB'(COORD_HI);
      1: return CB'(COORD_LO);
      2: return '0;
      3: return '1;
      default: return CB'($urandom);
    endcase
  endfunction

  function automatic outline_op_t noise_op();
    outline_op_t op;
    op.cmd              = 1'($urandom_range(0, 1));
    op.side_index       = IDX_BITS'($urandom);
    op.side_is_vertical = 1'($urandom_range(0, 1));
    op.side_position    = any_coord();
    op.vertex_x         = any_coord();
    op.vertex_y         = any_coord();
    op.query_x          = any_coord();
    op.query_y          = any_coord();
    return op;
  endfunction

  function automatic outline_op_t side_load(int idx, bit vert, longint pos,
                                            longint x, longint y);
    outline_op_t op;
    op.cmd              = CMD_LOAD;
    op.side_index       = IDX_BITS'(idx);
    op.side_is_vertical = vert;
    op.side_position    = CB'(pos);
    op.vertex_x         = CB'(x);
    op.vertex_y         = CB'(y);
    op.query_x          = CB'(COORD_HI);
    op.query_y          = CB'(COORD_LO);
    return op;
  endfunction

  function automatic outline_op_t pin_query(longint x, longint y);
    outline_op_t op;
    op.cmd              = CMD_QUERY;
    op.side_index       = '1;
    op.side_is_vertical = 1'b1;
    op.side_position    = CB'(COORD_LO);
    op.vertex_x         = CB'(COORD_HI);
    op.vertex_y         = CB'(COORD_LO);
    op.query_x          = CB'(x);
    op.query_y          = CB'(y);
    return op;
  endfunction

  task automatic put_item(input outline_op_t op, input logic typed,
                          input logic [IDX_BITS-1:0] answer);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd              <= op.cmd;
    side_index       <= op.side_index;
    side_is_vertical <= op.side_is_vertical;
    side_position    <= op.side_position;
    vertex_x         <= op.vertex_x;
    vertex_y         <= op.vertex_y;
    query_x          <= op.query_x;
    query_y          <= op.query_y;
    answer_typed     <= typed;
    answer_given     <= answer;
    in_valid         <= 1'b1;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic put_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [CB-1:0] data);
    @(negedge clk);
    cfg_index <= idx;
    cfg_data  <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_nearest.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // closed rectilinear outline: odd sides horizontal, even sides vertical
  task automatic load_outline(input int count, input longint cx, input longint cy);
    longint      hy [1:SIDES];
    longint      xv [1:SIDES];
    int          nv;
    outline_op_t op;
    nv = (count < 2) ? 2 : count + (count % 2);
    for (int k = 1; k <= nv; k++) begin
      hy[k] = rel(REACH);
      xv[k] = rel(REACH);
    end
    for (int k = 1; k <= nv; k++) begin
      op = noise_op();
      op.cmd = CMD_LOAD;
      op.side_index = IDX_BITS'(k);
      if (k % 2 == 1) begin
        op.side_is_vertical = 1'b0;
        op.side_position = clamp_coord(hy[k] + cy);
        op.vertex_x = CB'(xv[(k == 1) ? nv : k - 1]);
        op.vertex_y = CB'(hy[k]);
      end else begin
        op.side_is_vertical = 1'b1;
        op.side_position = clamp_coord(xv[k] + cx);
        op.vertex_x = CB'(xv[k]);
        op.vertex_y = CB'(hy[k - 1]);
      end
      put_item(op, 1'b0, NO_COVER_SIDE);
    end
  endtask

  initial begin : stimulus
    int            sides_plan [PHASES];
    outline_op_t   op;
    logic [CB-1:0] data;
    longint        cx, cy;
    int            r;
    bit            vert;

    sides_plan = '{16, 0, 1, 31, 2, 6, 17, 3, 8, 12, 5, 16};

    // square of side 200 around the origin, then ignored loads, pins around it and side reloads
    dir_rows.push_back('{side_load(1, 0, -100, -100, -100), 1'b0, NO_COVER_SIDE});
    dir_rows.push_back('{side_load(2, 1, 100, 100, -100), 1'b0, NO_COVER_SIDE});
    dir_rows.push_back('{side_load(3, 0, 100, 100, 100), 1'b0, NO_COVER_SIDE});
    dir_rows.push_back('{side_load(4, 1, -100, -100, 100), 1'b0, NO_COVER_SIDE});
    dir_rows.push_back('{side_load(0, 1, COORD_HI, COORD_LO, COORD_HI), 1'b0, NO_COVER_SIDE});
    dir_rows.push_back('{side_load(17, 0, COORD_LO, COORD_HI, COORD_LO), 1'b0, NO_COVER_SIDE});
    dir_rows.push_back('{side_load(31, 1, COORD_HI, COORD_HI, COORD_HI), 1'b0, NO_COVER_SIDE});
    dir_rows.push_back('{pin_query(0, 0), 1'b1, 5'd1});
    dir_rows.push_back('{pin_query(90, 0), 1'b1, 5'd2});
    dir_rows.push_back('{pin_query(0, 90), 1'b1, 5'd3});
    dir_rows.push_back('{pin_query(-90, 0), 1'b1, 5'd4});
    dir_rows.push_back('{pin_query(0, -90), 1'b1, 5'd1});
    dir_rows.push_back('{pin_query(100, -100), 1'b1, 5'd1});
    dir_rows.push_back('{pin_query(100, 50), 1'b1, 5'd2});
    dir_rows.push_back('{pin_query(1000, 1000), 1'b1, NO_COVER_SIDE});
    dir_rows.push_back('{pin_query(COORD_HI, COORD_HI), 1'b1, NO_COVER_SIDE});
    dir_rows.push_back('{pin_query(COORD_LO, COORD_LO), 1'b1, NO_COVER_SIDE});
    dir_rows.push_back('{side_load(1, 0, COORD_LO, -100, -100), 1'b0, NO_COVER_SIDE});
    dir_rows.push_back('{pin_query(0, 0), 1'b1, 5'd2});
    dir_rows.push_back('{pin_query(0, COORD_LO), 1'b1, 5'd1});
    dir_rows.push_back('{side_load(16, 1, COORD_HI, COORD_LO, COORD_HI), 1'b0, NO_COVER_SIDE});
    dir_rows.push_back('{pin_query(-37, 12), 1'b0, NO_COVER_SIDE});
    dir_rows.push_back('{side_load(1, 0, -100, -100, -100), 1'b0, NO_COVER_SIDE});
    dir_rows.push_back('{pin_query(55, -99), 1'b0, NO_COVER_SIDE});

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      put_item(dir_rows[i].op, dir_rows[i].typed, dir_rows[i].answer);
    end

    for (int p = 0; p < PHASES; p++) begin
      settle();
      case (p % 4)
        0: begin
          cx = rel(1 << 20);
          cy = rel(1 << 20);
        end
        1: begin
          cx = COORD_HI;
          cy = COORD_LO;
        end
        2: begin
          cx = COORD_LO;
          cy = COORD_HI;
        end
        default: begin
          cx = longint'($signed(any_coord()));
          cy = longint'($signed(any_coord()));
        end
      endcase
      stall_mode = p % 3;
      data = CB'($urandom);
      data[IDX_BITS-1:0] = IDX_BITS'(sides_plan[p]);
      put_reg(CFG_NUM_SIDES, data);
      put_reg(CFG_CENTER_X, CB'(cx));
      put_reg(CFG_CENTER_Y, CB'(cy));
      if (p % 2 == 1) begin
        put_reg(CFG_UNUSED, any_coord());
      end
      @(negedge clk);
      cfg_valid <= 1'b0;

      load_outline((sides_plan[p] > SIDES) ? SIDES : sides_plan[p], cx, cy);

      repeat (PHASE_ITEMS) begin
        op = noise_op();
        r = $urandom_range(0, 99);
        if (r < 55) begin
          op.cmd = CMD_QUERY;
          op.query_x = clamp_coord(cx + rel(REACH + 8));
          op.query_y = clamp_coord(cy + rel(REACH + 8));
        end else if (r < 65) begin
          op.cmd = CMD_QUERY;
        end else if (r < 90) begin
          vert = 1'($urandom_range(0, 1));
          op.cmd = CMD_LOAD;
          op.side_index = IDX_BITS'($urandom_range(1, SIDES));
          op.side_is_vertical = vert;
          op.side_position = clamp_coord((vert ? cx : cy) + rel(REACH));
          op.vertex_x = CB'(rel(REACH));
          op.vertex_y = CB'(rel(REACH));
        end else begin
          op.cmd = CMD_LOAD;
        end
        put_item(op, 1'b0, NO_COVER_SIDE);
      end
    end

    settle();
    if (pending_nearest.size() != 0) begin
      $display("%0d expected results never arrived", pending_nearest.size());
      mismatches += pending_nearest.size();
    end
    $display("%0d side loads and %0d pin queries over %0d register settings, %0d writes",
             loads_seen, queries_seen, PHASES + 1, reg_writes);
    $display("%0d results compared, %0d mismatches", results_seen, mismatches);
    if (mismatches == 0) begin
      $display("PASS nearest_polygon_side");
    end else begin
      $display("FAIL nearest_polygon_side");
    end
    $finish;
  end

endmodule

FILE: nearest_polygon_side.f
rtl/nps_pkg.sv
rtl/nps_ram.sv
rtl/nps_ctrl.sv
rtl/nps_datapath.sv
rtl/nearest_polygon_side.sv
tb/sv/nearest_polygon_side_test.sv
